// ----- hw/rtl/smpq_pkg.sv -----
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and codes of the sorted max-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  // operation codes of an input transaction
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic ins_en;
    logic pop_en;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/smpq_in_if.sv -----
// ----------------------------------------------------------------------------
// smpq_in_if
// Request channel: operation code and value to insert.
// ----------------------------------------------------------------------------
interface smpq_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
) ();
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// ----- hw/rtl/smpq_out_if.sv -----
// ----------------------------------------------------------------------------
// smpq_out_if
// Result channel: popped value, status code and entry count.
// ----------------------------------------------------------------------------
interface smpq_out_if #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH = 5
) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] popped_value;
  logic [1:0]             status;
  logic [COUNT_WIDTH-1:0] entry_count;

  modport source (output valid, output popped_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input entry_count,
                  output ready);
endinterface

// ----- hw/rtl/sorted_max_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_max_priority_queue
// Bounded max-priority queue kept as a descending chain of cells.
// ----------------------------------------------------------------------------
//  channel  dir  payload                              handshake
//  in_i     in   operation, value                     valid / ready
//  out_o    out  popped_value, status, entry_count    valid / ready
//
//  one transaction per cycle unless the result stalls: every cell compares
//  its entry with the incoming value in parallel and the whole chain shifts
//  at once. each request yields one result, held in an output register; a
//  new request is taken when none is held or in the same cycle it is taken.
//  reset clears the entry count and the result valid; entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  smpq_in_if.sink    in_i,
  smpq_out_if.source out_o
);

  localparam int unsigned CountWidth = $clog2(CAPACITY + 1);

  logic [CountWidth-1:0]  count_q, count_d;
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] popped_q, popped_d;
  smpq_pkg::status_e      status_q, status_d;
  logic                   accept;
  logic                   is_full, is_empty;
  smpq_pkg::cell_cmd_t    cmd;

  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]    cell_ge;
  logic [CAPACITY-1:0]    occupied;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_full    = (count_q == CountWidth'(CAPACITY));
  assign is_empty   = (count_q == '0);

  assign cmd.ins_en = accept && (in_i.operation == smpq_pkg::OP_INSERT) && !is_full;
  assign cmd.pop_en = accept && (in_i.operation == smpq_pkg::OP_POP) && !is_empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_value, next_value;
    logic                   prev_ge;

    assign occupied[i] = (CountWidth'(i) < count_q);

    if (i == 0) begin : g_head
      // the head takes a newcomer unless it keeps its own entry
      assign prev_value = in_i.value;
      assign prev_ge    = 1'b1;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_ge    = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = cell_value[i];
    end else begin : g_link
      assign next_value = cell_value[i+1];
    end

    smpq_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (occupied[i]),
      .new_value_i  (in_i.value),
      .prev_value_i (prev_value),
      .prev_ge_i    (prev_ge),
      .next_value_i (next_value),
      .value_o      (cell_value[i]),
      .ge_o         (cell_ge[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    popped_d = '0;
    status_d = smpq_pkg::STATUS_OK;
    if (in_i.operation == smpq_pkg::OP_INSERT) begin
      if (is_full) begin
        status_d = smpq_pkg::STATUS_FULL;
      end else begin
        count_d = count_q + CountWidth'(1);
      end
    end else begin
      if (is_empty) begin
        popped_d = '1;
        status_d = smpq_pkg::STATUS_EMPTY;
      end else begin
        popped_d = cell_value[0];
        count_d  = count_q - CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = popped_q;
  assign out_o.status       = status_q;
  assign out_o.entry_count  = count_q;

endmodule

// ----- hw/rtl/smpq_cell.sv -----
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: holds an entry, compares it with the value
// being inserted and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module smpq_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                     clk_i,
  input  smpq_pkg::cell_cmd_t      cmd_i,
  input  logic                     occupied_i,
  input  logic [VALUE_WIDTH-1:0]   new_value_i,
  input  logic [VALUE_WIDTH-1:0]   prev_value_i,
  input  logic                     prev_ge_i,
  input  logic [VALUE_WIDTH-1:0]   next_value_i,
  output logic [VALUE_WIDTH-1:0]   value_o,
  output logic                     ge_o
);

  logic [VALUE_WIDTH-1:0] value_q, value_d;

  // entry stays ahead of an equal newcomer
  assign ge_o = occupied_i && ($signed(value_q) >= $signed(new_value_i));

  always_comb begin
    value_d = value_q;
    if (cmd_i.ins_en) begin
      if (!ge_o) begin
        value_d = prev_ge_i ? new_value_i : prev_value_i;
      end
    end else if (cmd_i.pop_en) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ----- bench/tb_sorted_max_priority_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_max_priority_queue
// Self-checking bench for the sorted max-priority queue: a short table of
// directed requests (empty pop, value extremes, ties, full rejection) and
// then random insert/pop traffic in phases with idle and stall patterns on
// both channels. Every result is compared with its typed row or a shadow queue.
// ----------------------------------------------------------------------------
module tb_sorted_max_priority_queue;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned COUNT_WIDTH = 5;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          DIRECTED_ROWS = 23;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    value_t                 popped;
    smpq_pkg::status_e      status;
    logic [COUNT_WIDTH-1:0] count;
  } queue_result_t;

  typedef struct packed {
    logic          op;
    value_t        value;
    logic          typed;
    queue_result_t result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  smpq_in_if  #(.VALUE_WIDTH(VALUE_WIDTH))                           req_if ();
  smpq_out_if #(.VALUE_WIDTH(VALUE_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) rsp_if ();

  sorted_max_priority_queue #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_if.sink),
    .out_o (rsp_if.source)
  );

  always #2 clk = ~clk;

  // shadow of the queue contents, largest first
  value_t        shadow_entries[$];
  queue_result_t awaited_results[$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            stall_pct = 0;
  int            hold_request = 0;

  // typed expectations only where they are obvious
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{smpq_pkg::OP_POP,    32'h0000_0000, 1'b1,
      '{-32'sd1, smpq_pkg::STATUS_EMPTY, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'h7fff_ffff, 1'b1, '{32'sd0, smpq_pkg::STATUS_OK, 5'd1}},
    '{smpq_pkg::OP_INSERT, 32'h8000_0000, 1'b1, '{32'sd0, smpq_pkg::STATUS_OK, 5'd2}},
    '{smpq_pkg::OP_INSERT, 32'h0000_0000, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'hffff_ffff, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_POP,    32'hffff_ffff, 1'b1,
      '{32'h7fff_ffff, smpq_pkg::STATUS_OK, 5'd5}},
    '{smpq_pkg::OP_INSERT, 32'h0000_0003, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, -32'sd7,       1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'h0000_0064, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, -32'sd100,     1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'h0000_0002, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'h0000_0002, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'h0000_0001, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'h5555_5555, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'haaaa_aaaa, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'h0000_0008, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'h0000_0009, 1'b1,
      '{32'sd0, smpq_pkg::STATUS_FULL, 5'd16}},
    '{smpq_pkg::OP_POP,    32'h0000_0000, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_POP,    32'h1234_5678, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}},
    '{smpq_pkg::OP_INSERT, 32'h0000_007b, 1'b0, '{32'sd0, smpq_pkg::STATUS_OK, 5'd0}}
  };

  // apply one request to the shadow queue and return the result it yields
  function automatic queue_result_t next_queue_result(logic op, value_t v);
    queue_result_t r;
    int            pos;
    r.popped = '0;
    r.status = smpq_pkg::STATUS_OK;
    if (op == smpq_pkg::OP_INSERT) begin
      if (shadow_entries.size() >= CAPACITY) begin
        r.status = smpq_pkg::STATUS_FULL;
      end else begin
        // ties go behind existing equal entries
        pos = 0;
        while (pos < shadow_entries.size() && shadow_entries[pos] >= v) pos++;
        shadow_entries.insert(pos, v);
      end
    end else if (shadow_entries.size() == 0) begin
      r.popped = -1;
      r.status = smpq_pkg::STATUS_EMPTY;
    end else begin
      r.popped = shadow_entries.pop_front();
    end
    r.count = COUNT_WIDTH'(shadow_entries.size());
    return r;
  endfunction

  function automatic value_t random_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3, 4: return value_t'($urandom_range(7)) - 4;
      5:       return $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
      default: return value_t'($urandom);
    endcase
  endfunction

  // present one request, with a random lead-in gap, and wait for its transaction
  task automatic offer_request(logic op, value_t v, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.value     <= v;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
  endtask

  task automatic run_random(int items, int idle_pct);
    int   insert_pct;
    logic op;
    value_t v;
    insert_pct = 50;
    for (int n = 0; n < items; n++) begin
      // shift the insert/pop mix now and then so the queue swings full and empty
      if (n % 20 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      op = ($urandom_range(99) < insert_pct) ? smpq_pkg::OP_INSERT : smpq_pkg::OP_POP;
      v  = random_value();
      offer_request(op, v, idle_pct);
      awaited_results.push_back(next_queue_result(op, v));
    end
  endtask

  // result side: check each transaction, then pick ready for the next cycle
  initial begin
    int            hold_left;
    logic          hold_taken;
    queue_result_t exp;
    hold_left = 0;
    hold_taken = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t unexpected result: popped_value %0d status %0d entry_count %0d",
                   $time, $signed(rsp_if.popped_value), rsp_if.status, rsp_if.entry_count);
          error_count++;
        end else begin
          exp = awaited_results.pop_front();
          if (rsp_if.popped_value !== exp.popped) begin
            $display("%0t popped_value mismatch: expected %0d, got %0d",
                     $time, exp.popped, $signed(rsp_if.popped_value));
            error_count++;
          end
          if (rsp_if.status !== exp.status) begin
            $display("%0t status mismatch: expected %0d, got %0d",
                     $time, exp.status, rsp_if.status);
            error_count++;
          end
          if (rsp_if.entry_count !== exp.count) begin
            $display("%0t entry_count mismatch: expected %0d, got %0d",
                     $time, exp.count, rsp_if.entry_count);
            error_count++;
          end
        end
      end
      if (hold_request > 0 && !hold_taken) begin
        hold_left = hold_request;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    directed_row_t row;
    req_if.valid     = 1'b0;
    req_if.operation = smpq_pkg::OP_INSERT;
    req_if.value     = '0;
    rst_n            = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    stall_pct = 0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      offer_request(row.op, row.value, 0);
      if (row.typed) begin
        void'(next_queue_result(row.op, row.value));
        awaited_results.push_back(row.result);
      end else begin
        awaited_results.push_back(next_queue_result(row.op, row.value));
      end
    end

    stall_pct = 0;
    run_random(300, 0);
    run_random(300, 79);
    stall_pct = 79;
    run_random(300, 0);
    stall_pct = 23;
    run_random(300, 23);

    // long receiver hold-off while requests keep coming
    stall_pct = 0;
    hold_request = 400;
    run_random(130, 0);

    req_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
